// ===== rtl/lled_pkg.sv =====
// ----------------------------------------------------------------------------
// lled_pkg
// Shared types, codes and defaults of the light latency edge detector.
// ----------------------------------------------------------------------------
package lled_pkg;

    localparam int AVG_POINTS_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF   = 48;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam int THR_HIGH_TO_MID_RST = 190;
    localparam int THR_MID_TO_LOW_RST  = 20;
    localparam int THR_LOW_TO_MID_RST  = 30;
    localparam int THR_MID_TO_HIGH_RST = 200;

    typedef enum logic [1:0] {
        REG_THR_HIGH_TO_MID = 2'd0,
        REG_THR_MID_TO_LOW  = 2'd1,
        REG_THR_LOW_TO_MID  = 2'd2,
        REG_THR_MID_TO_HIGH = 2'd3
    } lled_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_BLINK  = 1'b1
    } lled_op_t;

    typedef enum logic [2:0] {
        LVL_UNKNOWN  = 3'd0,
        LVL_HIGH     = 3'd1,
        LVL_LOW      = 3'd2,
        LVL_FALL_MID = 3'd3,
        LVL_RISE_MID = 3'd4
    } lled_level_t;

    typedef enum logic [1:0] {
        BLK_UNKNOWN = 2'd0,
        BLK_HIGH    = 2'd1,
        BLK_LOW     = 2'd2
    } lled_blink_t;

    typedef enum logic {
        EDGE_RISE = 1'b0,
        EDGE_FALL = 1'b1
    } lled_edge_t;

    // Kind of word moving down the pipeline
    typedef struct packed {
        lled_op_t opcode;
        logic     blink_level;
    } lled_tag_t;

endpackage

// ===== rtl/lled_if.sv =====
// ----------------------------------------------------------------------------
// lled_in_if / lled_out_if
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
interface lled_in_if #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 48
);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   blink_level;
    logic [TIME_BITS-1:0]   time_us;

    modport source (output valid, opcode, sample, blink_level, time_us, input ready);
    modport sink   (input valid, opcode, sample, blink_level, time_us, output ready);
endinterface

interface lled_out_if #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 48
);
    logic                        valid;
    logic                        ready;
    logic [2:0]                  sensor_level_state;
    logic [1:0]                  blink_status;
    logic                        edge_kind;
    logic [SAMPLE_BITS-1:0]      average;
    logic signed [TIME_BITS:0]   latency_rise;
    logic signed [TIME_BITS:0]   latency_fall;

    modport source (output valid, sensor_level_state, blink_status, edge_kind, average,
                    latency_rise, latency_fall, input ready);
    modport sink   (input valid, sensor_level_state, blink_status, edge_kind, average,
                    latency_rise, latency_fall, output ready);
endinterface

// ===== rtl/lled_cfg.sv =====
// ----------------------------------------------------------------------------
// lled_cfg
// APB threshold register file.
// ----------------------------------------------------------------------------
module lled_cfg
    import lled_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output logic [SAMPLE_BITS-1:0]   thr_high_to_mid,
    output logic [SAMPLE_BITS-1:0]   thr_mid_to_low,
    output logic [SAMPLE_BITS-1:0]   thr_low_to_mid,
    output logic [SAMPLE_BITS-1:0]   thr_mid_to_high
);

    logic [SAMPLE_BITS-1:0] thr_hm_reg;
    logic [SAMPLE_BITS-1:0] thr_ml_reg;
    logic [SAMPLE_BITS-1:0] thr_lm_reg;
    logic [SAMPLE_BITS-1:0] thr_mh_reg;
    logic                   wr_en;
    lled_reg_t              reg_idx;
    logic [SAMPLE_BITS-1:0] wr_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = lled_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
    assign wr_val  = pwdata[SAMPLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_hm_reg <= SAMPLE_BITS'(THR_HIGH_TO_MID_RST);
            thr_ml_reg <= SAMPLE_BITS'(THR_MID_TO_LOW_RST);
            thr_lm_reg <= SAMPLE_BITS'(THR_LOW_TO_MID_RST);
            thr_mh_reg <= SAMPLE_BITS'(THR_MID_TO_HIGH_RST);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_THR_HIGH_TO_MID: thr_hm_reg <= wr_val;
                REG_THR_MID_TO_LOW:  thr_ml_reg <= wr_val;
                REG_THR_LOW_TO_MID:  thr_lm_reg <= wr_val;
                REG_THR_MID_TO_HIGH: thr_mh_reg <= wr_val;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THR_HIGH_TO_MID: prdata = CFG_DATA_BITS'(thr_hm_reg);
            REG_THR_MID_TO_LOW:  prdata = CFG_DATA_BITS'(thr_ml_reg);
            REG_THR_LOW_TO_MID:  prdata = CFG_DATA_BITS'(thr_lm_reg);
            REG_THR_MID_TO_HIGH: prdata = CFG_DATA_BITS'(thr_mh_reg);
        endcase
    end

    assign thr_high_to_mid = thr_hm_reg;
    assign thr_mid_to_low  = thr_ml_reg;
    assign thr_low_to_mid  = thr_lm_reg;
    assign thr_mid_to_high = thr_mh_reg;

endmodule

// ===== rtl/lled_avg.sv =====
// ----------------------------------------------------------------------------
// lled_avg
// Sample ring with running sum, then floored average by reciprocal multiply.
// ----------------------------------------------------------------------------
module lled_avg
    import lled_pkg::*;
#(
    parameter int AVG_POINTS  = AVG_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    lled_in_if.sink                evt,
    output logic                   mid_valid,
    input  logic                   mid_ready,
    output lled_tag_t              mid_tag,
    output logic [TIME_BITS-1:0]   mid_time,
    output logic [SAMPLE_BITS-1:0] mid_avg
);

    localparam int POS_BITS  = (AVG_POINTS > 1) ? $clog2(AVG_POINTS) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(AVG_POINTS);
    localparam int SHIFT     = SUM_BITS + $clog2(AVG_POINTS);
    localparam int MULT_BITS = SUM_BITS + 1;
    localparam int PROD_BITS = SUM_BITS + MULT_BITS;
    // ceil(2^SHIFT / AVG_POINTS): exact quotient for every sum below 2^SUM_BITS
    localparam logic [MULT_BITS-1:0] RECIP =
        MULT_BITS'(((64'd1 << SHIFT) + 64'(AVG_POINTS) - 64'd1) / 64'(AVG_POINTS));

    logic [SAMPLE_BITS-1:0] ring_reg [AVG_POINTS];
    logic [POS_BITS-1:0]    pos_reg;
    logic [POS_BITS-1:0]    pos_next;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;

    logic                   s1_valid_reg;
    lled_tag_t              s1_tag_reg;
    logic [TIME_BITS-1:0]   s1_time_reg;
    logic [SUM_BITS-1:0]    s1_sum_reg;
    logic                   s1_ready;

    logic                   s2_valid_reg;
    lled_tag_t              s2_tag_reg;
    logic [TIME_BITS-1:0]   s2_time_reg;
    logic [SAMPLE_BITS-1:0] s2_avg_reg;
    logic [PROD_BITS-1:0]   prod;

    lled_tag_t              evt_tag;
    logic                   evt_take;
    logic                   s1_move;

    assign evt_tag.opcode      = lled_op_t'(evt.opcode);
    assign evt_tag.blink_level = evt.blink_level;

    assign s1_ready  = !s2_valid_reg || mid_ready;
    assign evt.ready = !s1_valid_reg || s1_ready;
    assign evt_take  = evt.valid && evt.ready;
    assign s1_move   = s1_valid_reg && s1_ready;

    assign sum_next = sum_reg + SUM_BITS'(evt.sample) - SUM_BITS'(ring_reg[pos_reg]);
    assign pos_next = (pos_reg == POS_BITS'(AVG_POINTS - 1)) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVG_POINTS; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else if (evt_take && evt_tag.opcode == OP_SAMPLE)
        begin
            ring_reg[pos_reg] <= evt.sample;
            pos_reg           <= pos_next;
            sum_reg           <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                s1_valid_reg <= evt.valid;
            end
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            s1_tag_reg  <= evt_tag;
            s1_time_reg <= evt.time_us;
            s1_sum_reg  <= sum_next;
        end
        if (s1_move)
        begin
            s2_tag_reg  <= s1_tag_reg;
            s2_time_reg <= s1_time_reg;
            s2_avg_reg  <= prod[SHIFT +: SAMPLE_BITS];
        end
    end

    assign prod = PROD_BITS'(s1_sum_reg) * PROD_BITS'(RECIP);

    assign mid_valid = s2_valid_reg;
    assign mid_tag   = s2_tag_reg;
    assign mid_time  = s2_time_reg;
    assign mid_avg   = s2_avg_reg;

endmodule

// ===== rtl/lled_edge.sv =====
// ----------------------------------------------------------------------------
// lled_edge
// Hysteresis level machine, blink and edge time capture, result register.
// ----------------------------------------------------------------------------
module lled_edge
    import lled_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   mid_valid,
    output logic                   mid_ready,
    input  lled_tag_t              mid_tag,
    input  logic [TIME_BITS-1:0]   mid_time,
    input  logic [SAMPLE_BITS-1:0] mid_avg,
    input  logic [SAMPLE_BITS-1:0] thr_high_to_mid,
    input  logic [SAMPLE_BITS-1:0] thr_mid_to_low,
    input  logic [SAMPLE_BITS-1:0] thr_low_to_mid,
    input  logic [SAMPLE_BITS-1:0] thr_mid_to_high,
    lled_out_if.source             result
);

    lled_level_t            level_reg;
    lled_level_t            level_next;
    lled_blink_t            blink_reg;
    logic [TIME_BITS-1:0]   blink_hi_time_reg;
    logic [TIME_BITS-1:0]   blink_lo_time_reg;
    logic [TIME_BITS-1:0]   rise_time_reg;
    logic [TIME_BITS-1:0]   fall_time_reg;

    logic                   edge_hit;
    lled_edge_t             edge_kind;
    logic [TIME_BITS-1:0]   rise_time_new;
    logic [TIME_BITS-1:0]   fall_time_new;

    logic                   res_valid_reg;
    logic                   res_valid_next;
    lled_level_t            res_level_reg;
    lled_blink_t            res_blink_reg;
    lled_edge_t             res_kind_reg;
    logic [SAMPLE_BITS-1:0] res_avg_reg;
    logic [TIME_BITS:0]     res_lat_rise_reg;
    logic [TIME_BITS:0]     res_lat_fall_reg;

    logic                   take;
    logic                   take_sample;
    logic                   take_blink;

    assign mid_ready   = !res_valid_reg || result.ready;
    assign take        = mid_valid && mid_ready;
    assign take_sample = take && mid_tag.opcode == OP_SAMPLE;
    assign take_blink  = take && mid_tag.opcode == OP_BLINK;

    // next state
    always_comb
    begin
        level_next = level_reg;
        unique case (level_reg)
            LVL_UNKNOWN:
            begin
                priority if (mid_avg <= thr_mid_to_low)
                    level_next = LVL_LOW;
                else if (mid_avg >= thr_mid_to_high)
                    level_next = LVL_HIGH;
                else
                    level_next = LVL_UNKNOWN;
            end
            LVL_HIGH:
                level_next = (mid_avg <= thr_high_to_mid) ? LVL_FALL_MID : LVL_HIGH;
            LVL_FALL_MID:
                level_next = (mid_avg <= thr_mid_to_low) ? LVL_LOW : LVL_FALL_MID;
            LVL_LOW:
                level_next = (mid_avg >= thr_low_to_mid) ? LVL_RISE_MID : LVL_LOW;
            LVL_RISE_MID:
                level_next = (mid_avg >= thr_mid_to_high) ? LVL_HIGH : LVL_RISE_MID;
            default:
                level_next = LVL_UNKNOWN;
        endcase
    end

    // edge decode
    always_comb
    begin
        edge_hit  = 1'b0;
        edge_kind = EDGE_RISE;
        if (level_reg == LVL_LOW && level_next == LVL_RISE_MID)
        begin
            edge_hit  = 1'b1;
            edge_kind = EDGE_RISE;
        end
        else if (level_reg == LVL_HIGH && level_next == LVL_FALL_MID)
        begin
            edge_hit  = 1'b1;
            edge_kind = EDGE_FALL;
        end
    end

    assign rise_time_new = (edge_kind == EDGE_RISE) ? mid_time : rise_time_reg;
    assign fall_time_new = (edge_kind == EDGE_FALL) ? mid_time : fall_time_reg;

    always_comb
    begin
        priority if (take)
            res_valid_next = take_sample && edge_hit;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg         <= LVL_UNKNOWN;
            blink_reg         <= BLK_UNKNOWN;
            blink_hi_time_reg <= '0;
            blink_lo_time_reg <= '0;
            rise_time_reg     <= '0;
            fall_time_reg     <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (take_blink)
            begin
                if (mid_tag.blink_level)
                begin
                    blink_hi_time_reg <= mid_time;
                    blink_reg         <= BLK_HIGH;
                end
                else
                begin
                    blink_lo_time_reg <= mid_time;
                    blink_reg         <= BLK_LOW;
                end
            end
            if (take_sample)
            begin
                level_reg <= level_next;
                if (edge_hit)
                begin
                    rise_time_reg <= rise_time_new;
                    fall_time_reg <= fall_time_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_sample && edge_hit)
        begin
            res_level_reg    <= level_next;
            res_blink_reg    <= blink_reg;
            res_kind_reg     <= edge_kind;
            res_avg_reg      <= mid_avg;
            res_lat_rise_reg <= {1'b0, rise_time_new} - {1'b0, blink_hi_time_reg};
            res_lat_fall_reg <= {1'b0, fall_time_new} - {1'b0, blink_lo_time_reg};
        end
    end

    assign result.valid              = res_valid_reg;
    assign result.sensor_level_state = res_level_reg;
    assign result.blink_status       = res_blink_reg;
    assign result.edge_kind          = res_kind_reg;
    assign result.average            = res_avg_reg;
    assign result.latency_rise       = res_lat_rise_reg;
    assign result.latency_fall       = res_lat_fall_reg;

endmodule

// ===== rtl/light_latency_edge_detector_top.sv =====
// ----------------------------------------------------------------------------
// light_latency_edge_detector_top
// Display-to-sensor latency: sample averaging, hysteresis edges, latencies.
//
//   port     dir  kind            word
//   evt      in   valid/ready     opcode, sample, blink_level, time_us
//   result   out  valid/ready     level, blink, edge, average, two latencies
//   apb      in   APB write/read  four thresholds at 4*i
//
// One word per cycle while result is not stalled; an event moves through the sum
// stage, the reciprocal multiply stage, then the level machine and result register.
// Level state updates at most once per cycle, on sample words in the last stage, which sets the rate.
// rst_n clears ring, sum, states and captured times at once.
// A stalled result holds; upstream stages keep filling until all are full.
// ----------------------------------------------------------------------------
module light_latency_edge_detector_top
    import lled_pkg::*;
#(
    parameter int AVG_POINTS  = AVG_POINTS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    lled_in_if.sink                  evt,
    lled_out_if.source               result,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [SAMPLE_BITS-1:0] thr_high_to_mid;
    logic [SAMPLE_BITS-1:0] thr_mid_to_low;
    logic [SAMPLE_BITS-1:0] thr_low_to_mid;
    logic [SAMPLE_BITS-1:0] thr_mid_to_high;

    logic                   mid_valid;
    logic                   mid_ready;
    lled_tag_t              mid_tag;
    logic [TIME_BITS-1:0]   mid_time;
    logic [SAMPLE_BITS-1:0] mid_avg;

    lled_cfg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .thr_high_to_mid (thr_high_to_mid),
        .thr_mid_to_low  (thr_mid_to_low),
        .thr_low_to_mid  (thr_low_to_mid),
        .thr_mid_to_high (thr_mid_to_high)
    );

    lled_avg #(
        .AVG_POINTS  (AVG_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .mid_valid (mid_valid),
        .mid_ready (mid_ready),
        .mid_tag   (mid_tag),
        .mid_time  (mid_time),
        .mid_avg   (mid_avg)
    );

    lled_edge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_edge (
        .clk             (clk),
        .rst_n           (rst_n),
        .mid_valid       (mid_valid),
        .mid_ready       (mid_ready),
        .mid_tag         (mid_tag),
        .mid_time        (mid_time),
        .mid_avg         (mid_avg),
        .thr_high_to_mid (thr_high_to_mid),
        .thr_mid_to_low  (thr_mid_to_low),
        .thr_low_to_mid  (thr_low_to_mid),
        .thr_mid_to_high (thr_mid_to_high),
        .result          (result)
    );

    // a new result only follows a sample word taken by the level stage
    a_result_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |->
            $past(mid_valid && mid_ready && mid_tag.opcode == OP_SAMPLE))
        else $error("result without a sample word");

    // a blink word never leaves a result behind
    a_blink_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid && mid_ready && mid_tag.opcode == OP_BLINK) |=> !result.valid)
        else $error("blink word produced a result");

    // the reported level matches the edge direction
    a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            ((result.edge_kind == EDGE_RISE && result.sensor_level_state == LVL_RISE_MID) ||
             (result.edge_kind == EDGE_FALL && result.sensor_level_state == LVL_FALL_MID)))
        else $error("edge kind and level disagree");

endmodule
